// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Request and response structs, operation and status codes, default depth.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_DEPTH = 64;

	// operation codes
	localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [2:0] FUNC_CLEAR      = 3'd4;
	localparam logic [2:0] FUNC_LIST       = 3'd5;

	// response status codes
	localparam logic [1:0] STAT_DONE       = 2'd0;
	localparam logic [1:0] STAT_ELEM       = 2'd1;
	localparam logic [1:0] STAT_LIST_EMPTY = 2'd2;
	localparam logic [1:0] STAT_FULL_DROP  = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic               last;
	} rsp_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Circular buffer with front index and entry count; push/pop at both ends,
// clear and list, one request at a time under a small sequencer.
// ----------------------------------------------------------------------------
// A request transfers on a rising edge with start high and busy low. Every
// request except list gives one response, registered as the execute state
// ends; list gives one response per stored value, front to back, one per
// cycle, the final one flagged by last (an empty queue lists as one "list
// empty" response). Responses appear for exactly one cycle with strobe high
// and cannot be held off, so the receiver must take them as they come. Push,
// pop, clear and unused codes pass through the accept and execute states;
// list passes through accept, execute and then one list step per element, as
// the single storage read port and the shared index adder step through the
// queue. The final response of a request shows in the cycle busy drops.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic strobe,
	output rsp_t rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t state_q;

	cmd_t          cmd_q;     // captured request
	logic [IW-1:0] front_q;   // slot of front element
	logic [CW-1:0] count_q;   // stored entries
	logic [CW-1:0] pos_q;     // list position

	// response path
	logic          ack_q;     // single response of a non-list request or of an empty list
	logic [1:0]    ack_stat_q;
	logic          elem_s1;   // listed element leaving storage read
	logic          elem_last_s1;

	// storage
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;

	// shared index adder
	logic [CW-1:0] offset;
	logic [IW-1:0] idx;

	logic full;
	logic empty;
	logic wr_en;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	dq_idx_unit #(.DEPTH(DEPTH)) u_idx (
		.base  (front_q),
		.offset(offset),
		.idx   (idx)
	);

	// Offset choice: front push steps back by one (DEPTH-1), back push
	// lands at front+count, front pop steps forward, listing walks pos.
	always_comb begin
		offset = pos_q;
		wr_en  = 1'b0;
		if (state_q == S_EXEC) begin
			unique case (cmd_q.func)
				FUNC_PUSH_FRONT: begin
					offset = CW'(DEPTH - 1);
					wr_en  = !full;
				end
				FUNC_PUSH_BACK: begin
					offset = count_q;
					wr_en  = !full;
				end
				FUNC_POP_FRONT: offset = CW'(1);
				default:        offset = pos_q;
			endcase
		end
	end

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= cmd_q.value;
		end
		rdata_q <= mem[idx];
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			pos_q        <= '0;
			ack_q        <= 1'b0;
			ack_stat_q   <= STAT_DONE;
			elem_s1      <= 1'b0;
			elem_last_s1 <= 1'b0;
		end else begin
			ack_q   <= 1'b0;
			elem_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= S_IDLE;
					ack_q      <= 1'b1;
					ack_stat_q <= STAT_DONE;
					unique case (cmd_q.func)
						FUNC_PUSH_FRONT: begin
							if (full) begin
								ack_stat_q <= STAT_FULL_DROP;
							end else begin
								front_q <= idx;
								count_q <= count_q + CW'(1);
							end
						end
						FUNC_PUSH_BACK: begin
							if (full) begin
								ack_stat_q <= STAT_FULL_DROP;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						FUNC_POP_FRONT: begin
							if (!empty) begin
								front_q <= idx;
								count_q <= count_q - CW'(1);
							end
						end
						FUNC_POP_BACK: begin
							if (!empty) begin
								count_q <= count_q - CW'(1);
							end
						end
						FUNC_CLEAR: begin
							front_q <= '0;
							count_q <= '0;
						end
						FUNC_LIST: begin
							if (empty) begin
								ack_stat_q <= STAT_LIST_EMPTY;
							end else begin
								ack_q   <= 1'b0;
								pos_q   <= '0;
								state_q <= S_LIST;
							end
						end
						default: ;  // unused codes: plain acknowledge
					endcase
				end
				S_LIST: begin
					// read of this slot issues now, data shows next cycle
					elem_s1      <= 1'b1;
					elem_last_s1 <= (pos_q + CW'(1) == count_q);
					pos_q        <= pos_q + CW'(1);
					if (pos_q + CW'(1) == count_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = ack_q | elem_s1;

	always_comb begin
		if (elem_s1) begin
			rsp.status = STAT_ELEM;
			rsp.data   = rdata_q;
			rsp.last   = elem_last_s1;
		end else begin
			rsp.status = ack_stat_q;
			rsp.data   = '0;
			rsp.last   = 1'b1;
		end
	end

endmodule

// ----- rtl/dq_idx_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_idx_unit: circular index adder
// Returns (base + offset) mod DEPTH for base < DEPTH and offset <= DEPTH.
// ----------------------------------------------------------------------------
module dq_idx_unit import dq_pkg::*; #(
	parameter int DEPTH = DQ_DEPTH,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic [IW-1:0] base,
	input  logic [CW-1:0] offset,
	output logic [IW-1:0] idx
);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	always_comb begin
		sum = (CW+1)'(base) + (CW+1)'(offset);
		// sum stays below twice the depth, so one subtract wraps it
		if (sum >= (CW+1)'(DEPTH)) begin
			wrapped = sum - (CW+1)'(DEPTH);
		end else begin
			wrapped = sum;
		end
		idx = wrapped[IW-1:0];
	end

endmodule
